// ===== hw/rtl/banked_memory_and_port_decoder_unit_defines.svh =====
// Assertion macros shared by the decoder RTL.
`ifndef BANKED_MEMORY_AND_PORT_DECODER_UNIT_DEFINES_SVH
`define BANKED_MEMORY_AND_PORT_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BMPD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BMPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/bmpd_pkg.sv =====
// Types and constants of the banked memory and port decoder.
package bmpd_pkg;

  // Transaction opcodes
  typedef enum logic [2:0] {
    OP_MEM_RD  = 3'd0,
    OP_MEM_WR  = 3'd1,
    OP_IO_RD   = 3'd2,
    OP_IO_WR   = 3'd3,
    OP_KEY_ROW = 3'd4
  } op_t;

  // External device flags
  typedef enum logic [2:0] {
    EXT_NONE      = 3'd0,
    EXT_SND_SEL   = 3'd1,
    EXT_SND_WR    = 3'd2,
    EXT_SND_RD    = 3'd3,
    EXT_MOUSE_BTN = 3'd4,
    EXT_MOUSE_X   = 3'd5,
    EXT_MOUSE_Y   = 3'd6
  } ext_t;

  // Address quarters
  typedef enum logic [1:0] {
    Q_ROM   = 2'd0,
    Q_FIX_A = 2'd1,
    Q_FIX_B = 2'd2,
    Q_PAGED = 2'd3
  } quarter_t;

  localparam int PG_W        = 6;
  localparam int PG_SHADOW   = 3;
  localparam int PG_ROM      = 4;
  localparam int PG_LOCK     = 5;
  localparam int KEY_ROWS    = 8;

  localparam logic [2:0] BANK_FIX_A = 3'd5;
  localparam logic [2:0] BANK_FIX_B = 3'd2;

  // Port low bytes
  localparam logic [7:0] LO_ULA     = 8'hFE;
  localparam logic [7:0] LO_SND     = 8'hFD;
  localparam logic [7:0] LO_SND_ALT = 8'hF5;
  localparam logic [7:0] LO_MOUSE   = 8'hDF;

  // Port high bytes
  localparam logic [7:0] HI_ALL_ROWS  = 8'h00;
  localparam logic [7:0] HI_FF        = 8'hFF;
  localparam logic [7:0] HI_PAGING    = 8'h7F;
  localparam logic [7:0] HI_SND_DATA  = 8'hBF;
  localparam logic [7:0] HI_SND_ALT   = 8'hC0;
  localparam logic [7:0] HI_MOUSE_BTN = 8'hFA;
  localparam logic [7:0] HI_MOUSE_X   = 8'hFB;

  // Floating bus read: set bits 5 and 7, clear bit 6
  localparam logic [7:0] FLOAT_SET = 8'hE0;
  localparam logic [7:0] FLOAT_CLR = 8'h40;

  localparam logic [7:0] KEYS_UP = 8'hFF;

  // Result payload held in the output register
  typedef struct packed {
    logic        mem_is_rom;
    logic [2:0]  mem_bank;
    logic [13:0] mem_offset;
    logic        mem_write;
    logic [7:0]  io_data;
    ext_t        external_target;
    logic        shadow_screen;
    logic [4:0]  border_code;
    logic        beeper;
  } rsp_t;

endpackage

// ===== hw/rtl/bmpd_if.sv =====
// Handshake channel interfaces: requests, results and configuration.
interface bmpd_req_if;
  import bmpd_pkg::*;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [15:0] address;
  logic [7:0]  data;
  logic [2:0]  key_row;
  modport source (output valid, op, address, data, key_row, input ready);
  modport sink (input valid, op, address, data, key_row, output ready);
endinterface

interface bmpd_rsp_if;
  import bmpd_pkg::*;
  logic        valid;
  logic        ready;
  logic        mem_is_rom;
  logic [2:0]  mem_bank;
  logic [13:0] mem_offset;
  logic        mem_write;
  logic [7:0]  io_data;
  logic [2:0]  external_target;
  logic        shadow_screen;
  logic [4:0]  border_code;
  logic        beeper;
  modport source (output valid, mem_is_rom, mem_bank, mem_offset, mem_write, io_data,
                  external_target, shadow_screen, border_code, beeper, input ready);
  modport sink (input valid, mem_is_rom, mem_bank, mem_offset, mem_write, io_data,
                external_target, shadow_screen, border_code, beeper, output ready);
endinterface

interface bmpd_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== hw/rtl/banked_memory_and_port_decoder_unit.sv =====
// Top level of the banked memory and port decoder.
//
// Decodes CPU memory and port transactions of a 128K banked machine. Each
// request transaction is decoded by one stage of logic into a result register,
// so the block takes one transaction per clock unless a result is stalled, and its
// result comes from the single output register in the cycle after acceptance; a
// stalled result blocks requests only while it waits. Memory transactions map to
// a ROM page or one of eight RAM banks; port writes update the paging, border
// and floating-bus registers; port reads return keyboard rows or the floating
// byte, or flag sound and mouse devices. The cfg channel sets mouse presence
// and is always ready; write it only while the block is idle.
`include "banked_memory_and_port_decoder_unit_defines.svh"

module banked_memory_and_port_decoder_unit (
  input  logic       clk,
  input  logic       rst,
  bmpd_req_if.sink   req,
  bmpd_rsp_if.source rsp,
  bmpd_cfg_if.sink   cfg
);
  import bmpd_pkg::*;

  // State
  logic [PG_W-1:0] paging;
  logic [7:0]      key_rows [KEY_ROWS];
  logic [7:0]      border_val;
  logic [7:0]      floating;
  logic            mouse_present;

  // Output register
  logic rsp_valid;
  rsp_t rsp_data;

  logic [PG_W-1:0] paging_next;
  logic [7:0]      border_next;
  logic [7:0]      floating_next;
  logic            key_wr;
  rsp_t            res;
  logic            accept;
  op_t             op;
  quarter_t        quarter;
  logic [7:0]      lo;
  logic [7:0]      hi;
  logic [2:0]      row_idx;
  logic            row_hit;
  logic [7:0]      rows_and;

  assign op      = op_t'(req.op);
  assign lo      = req.address[7:0];
  assign hi      = req.address[15:8];
  assign quarter = quarter_t'(req.address[15:14]);

  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign cfg.ready = 1'b1;

  // Keyboard row select: high byte with exactly one zero bit
  always_comb begin
    row_idx = '0;
    for (int n = 0; n < KEY_ROWS; n++) begin
      if (!hi[n]) row_idx = 3'(n);
    end
  end
  assign row_hit = $onehot(~hi);

  // AND of all keyboard rows
  always_comb begin
    rows_and = KEYS_UP;
    for (int n = 0; n < KEY_ROWS; n++) begin
      rows_and = rows_and & key_rows[n];
    end
  end

  // Decode of one transaction
  always_comb begin
    res           = '0;
    paging_next   = paging;
    border_next   = border_val;
    floating_next = floating;
    key_wr        = 1'b0;
    case (op)
      OP_MEM_RD, OP_MEM_WR: begin
        res.mem_offset = req.address[13:0];
        case (quarter)
          Q_ROM: begin
            res.mem_is_rom = 1'b1;
            res.mem_bank   = {2'b00, paging[PG_ROM]};
          end
          Q_FIX_A: res.mem_bank = BANK_FIX_A;
          Q_FIX_B: res.mem_bank = BANK_FIX_B;
          default: res.mem_bank = paging[2:0];
        endcase
        res.mem_write = (op == OP_MEM_WR) && (quarter != Q_ROM);
      end
      OP_IO_RD: begin
        if (lo == LO_ULA && row_hit) begin
          res.io_data = key_rows[row_idx];
        end else if (lo == LO_ULA && hi == HI_ALL_ROWS) begin
          res.io_data = rows_and;
        end else if (lo == LO_SND && hi == HI_FF) begin
          res.external_target = EXT_SND_RD;
        end else if (lo == LO_MOUSE && mouse_present && hi == HI_MOUSE_BTN) begin
          res.external_target = EXT_MOUSE_BTN;
        end else if (lo == LO_MOUSE && mouse_present && hi == HI_MOUSE_X) begin
          res.external_target = EXT_MOUSE_X;
        end else if (lo == LO_MOUSE && mouse_present && hi == HI_FF) begin
          res.external_target = EXT_MOUSE_Y;
        end else begin
          res.io_data = (floating | FLOAT_SET) & ~FLOAT_CLR;
        end
      end
      OP_IO_WR: begin
        if (lo == LO_ULA) begin
          border_next = req.data;
        end else if (lo == LO_SND_ALT) begin
          if (hi == HI_SND_ALT) res.external_target = EXT_SND_SEL;
        end else if (lo == LO_SND) begin
          if (hi == HI_FF) begin
            res.external_target = EXT_SND_SEL;
          end else if (hi == HI_SND_DATA) begin
            res.external_target = EXT_SND_WR;
          end else if (hi == HI_PAGING && !paging[PG_LOCK]) begin
            paging_next = req.data[PG_W-1:0];
          end
        end else begin
          floating_next = req.data;
        end
      end
      OP_KEY_ROW: key_wr = 1'b1;
      default: ;
    endcase
    // Display status after this transaction
    res.shadow_screen = paging_next[PG_SHADOW];
    res.border_code   = {border_next[0], 1'b0, border_next[2], 1'b0, border_next[1]};
    res.beeper        = border_next[4];
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      paging        <= '0;
      border_val    <= '0;
      floating      <= '0;
      mouse_present <= 1'b0;
      for (int n = 0; n < KEY_ROWS; n++) key_rows[n] <= KEYS_UP;
    end else begin
      if (cfg.valid) mouse_present <= cfg.data;
      if (accept) begin
        paging     <= paging_next;
        border_val <= border_next;
        floating   <= floating_next;
        if (key_wr) key_rows[req.key_row] <= req.data;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) rsp_data <= res;
  end

  assign rsp.valid           = rsp_valid;
  assign rsp.mem_is_rom      = rsp_data.mem_is_rom;
  assign rsp.mem_bank        = rsp_data.mem_bank;
  assign rsp.mem_offset      = rsp_data.mem_offset;
  assign rsp.mem_write       = rsp_data.mem_write;
  assign rsp.io_data         = rsp_data.io_data;
  assign rsp.external_target = rsp_data.external_target;
  assign rsp.shadow_screen   = rsp_data.shadow_screen;
  assign rsp.border_code     = rsp_data.border_code;
  assign rsp.beeper          = rsp_data.beeper;

  // Checks
  `BMPD_ASSERT_NOW(a_stall_blocks, rsp_valid && !rsp.ready, !req.ready, "request taken while result stalled")
  `BMPD_ASSERT_NEXT(a_accept_result, accept, rsp_valid, "accepted transaction produced no result")
  `BMPD_ASSERT_NEXT(a_lock_holds, paging[PG_LOCK], $stable(paging), "locked paging register changed")
  `BMPD_ASSERT_NOW(a_rom_no_write, rsp_valid, !(rsp_data.mem_write && rsp_data.mem_is_rom), "write strobe on ROM")

endmodule
